// File: rtl/tbg_pkg.sv
// ============================================================================
// tbg_pkg
// Shared types, register indexes and sine table helpers for the tone burst
// generator.
// ============================================================================
package tbg_pkg;

    // Configuration register indexes
    localparam logic REG_AMPLITUDE  = 1'b0;
    localparam logic REG_FADE_LIMIT = 1'b1;

    localparam int CFG_DATA_W  = 15;
    localparam int AMP_W       = 15;
    localparam int FADE_W      = 10;
    localparam int SINE_W      = 15;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = AMP_W + SINE_W;
    localparam int DIV_STEPS   = SINE_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd28000;
    localparam logic [FADE_W-1:0] FADE_RESET = 10'd400;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor divisors (2m)(2m+1) for m = 1..7
    localparam logic [63:0] TAYLOR_DIV [1:7] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // item transfer: latch item, advance burst state
        logic rom_rd;    // read the quarter-wave table
        logic mul;       // amplitude times sine magnitude
        logic div_init;  // envelope multiply, load divider
        logic div_step;  // one restoring division step
        logic out_load;  // load the result register
    } tbg_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fade_on;   // envelope ramp needs the divider
    } tbg_status_t;

    // Quarter-wave sine in Q15 at r / 2^(tbits-2) of pi/2; elaboration only
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned r,
                                                       input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        x    = (64'(r) * HALF_PI_Q30) >> (tbits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int m = 1; m <= 7; m++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[m];
            if (m % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32767)
            q = 64'd32767;
        return q[SINE_W-1:0];
    endfunction

endpackage

// File: rtl/tone_burst_generator.sv
// ============================================================================
// tone_burst_generator
// Sine tone burst source with a linear fade-in and fade-out envelope.
// ============================================================================
// Each input transfer yields exactly one result transfer. A start item
// (mode 1) loads the phase step and burst length and yields sample 0 of the
// new burst. A tick (mode 0) yields the next sample, or a zero sample with
// active low once the burst is over. On a fade ramp the result also passes
// through a 15-step restoring divider that scales by the fade length. The
// next item is taken in the cycle after the result is loaded. Ticks while
// idle after a burst that had a nonzero fade length also go through the
// divider. A result that waits at the output does not block the next item
// from being taken. That item then holds in its last step until the result
// register is free.
module tone_burst_generator #(
    parameter int PHASE_BITS = 32,
    parameter int TABLE_BITS = 10,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [tbg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [30:0]                         phase_step,
    input  logic [15:0]                         sample_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tbg_pkg::SAMPLE_W-1:0] sample,
    output logic                                active,
    output logic                                last
);
    import tbg_pkg::*;

    tbg_cmd_t    cmd;
    tbg_status_t status;

    // Sequencer
    tbg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    tbg_datapath #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .phase_step   (phase_step),
        .sample_count (sample_count),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .active       (active),
        .last         (last)
    );

    // One item at a time: no new transfer right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    // The final-sample flag only comes with a burst sample
    a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> active)
        else $error("last set on a non-burst result");

    // Results outside a burst are silent
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> sample == '0)
        else $error("nonzero sample with active low");

endmodule

// File: rtl/tbg_ctrl.sv
// ============================================================================
// tbg_ctrl
// Sequencer for the tone burst generator: item handshake, datapath steps,
// divider step count and the result handshake.
// ============================================================================
module tbg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tbg_pkg::tbg_status_t status,
    output tbg_pkg::tbg_cmd_t   cmd
);
    import tbg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROM  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROM;
                end
            end
            ST_ROM:
            begin
                cmd.rom_rd = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = status.fade_on ? ST_DIV : ST_OUT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/tbg_datapath.sv
// ============================================================================
// tbg_datapath
// Burst state, quarter-wave sine ROM, amplitude and envelope multipliers,
// restoring divider for the fade ramp, and the result register.
// ============================================================================
module tbg_datapath #(
    parameter int PHASE_BITS = 32,
    parameter int TABLE_BITS = 10,
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [tbg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               mode,
    input  logic [30:0]                        phase_step,
    input  logic [15:0]                        sample_count,
    input  tbg_pkg::tbg_cmd_t                  cmd,
    output tbg_pkg::tbg_status_t               status,
    output logic signed [tbg_pkg::SAMPLE_W-1:0] sample,
    output logic                               active,
    output logic                               last
);
    import tbg_pkg::*;

    localparam int QSZ    = 2 ** (TABLE_BITS - 2);
    localparam int ROM_AW = TABLE_BITS - 1;
    localparam int CMP_W  = COUNT_BITS + FADE_W + 1;

    typedef logic [SINE_W-1:0] qtab_t [QSZ+1];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int k = 0; k <= QSZ; k++)
            t[k] = quarter_sine(k, TABLE_BITS);
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    // Configuration and burst state
    logic [AMP_W-1:0]      amp_reg;
    logic [FADE_W-1:0]     fade_limit_reg;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PHASE_BITS-1:0] step_reg, step_next;
    logic [COUNT_BITS-1:0] index_reg, index_next;
    logic [COUNT_BITS-1:0] length_reg, length_next;
    logic [FADE_W-1:0]     fade_reg, fade_next;
    logic                  busy_reg, busy_next;

    // Per-item working registers
    logic                  act_reg, last_w_reg, sign_reg, fade_on_reg;
    logic [FADE_W-1:0]     num_reg, den_reg;
    logic [ROM_AW-1:0]     rom_addr_reg;
    logic [SINE_W-1:0]     rom_data_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [FADE_W-1:0]     rem_reg;
    logic [SINE_W-1:0]     dvd_reg;

    // Result register
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       active_reg, last_reg;

    // Item decode: effective burst state after an optional start
    logic [COUNT_BITS-1:0] n_in, q_in, eff_i, eff_n;
    logic [FADE_W-1:0]     fade_in, eff_f;
    logic [PHASE_BITS-1:0] eff_phase;
    logic                  eff_busy;
    logic [TABLE_BITS-1:0] tab_addr;
    logic [TABLE_BITS-3:0] tab_r;
    logic [ROM_AW-1:0]     rom_addr_next;
    logic [CMP_W-1:0]      i_w, f_w, n_w, ipf_w;
    logic                  in_ramp_up, in_ramp_down;
    logic [FADE_W-1:0]     num_next;

    assign n_in    = COUNT_BITS'(sample_count);
    assign q_in    = n_in >> 2;
    assign fade_in = (CMP_W'(fade_limit_reg) < CMP_W'(q_in)) ? fade_limit_reg
                                                             : FADE_W'(q_in);

    always_comb
    begin
        step_next   = step_reg;
        length_next = length_reg;
        fade_next   = fade_reg;
        eff_phase   = phase_reg;
        eff_i       = index_reg;
        eff_busy    = busy_reg;
        if (mode)
        begin
            step_next   = PHASE_BITS'({1'b0, phase_step});
            length_next = n_in;
            fade_next   = fade_in;
            eff_phase   = '0;
            eff_i       = '0;
            eff_busy    = (n_in != '0);
        end
    end

    assign eff_n = length_next;
    assign eff_f = fade_next;

    // Envelope selection
    assign i_w          = CMP_W'(eff_i);
    assign f_w          = CMP_W'(eff_f);
    assign n_w          = CMP_W'(eff_n);
    assign ipf_w        = i_w + f_w;
    assign in_ramp_up   = (eff_f != '0) && (i_w < f_w);
    assign in_ramp_down = (eff_f != '0) && !in_ramp_up && (ipf_w > n_w);
    assign num_next     = in_ramp_up ? FADE_W'(eff_i) : FADE_W'(eff_n - eff_i);

    // Quarter-wave table address with quadrant folding
    assign tab_addr      = eff_phase[PHASE_BITS-1 -: TABLE_BITS];
    assign tab_r         = tab_addr[TABLE_BITS-3:0];
    assign rom_addr_next = tab_addr[TABLE_BITS-2] ? (ROM_AW'(QSZ) - ROM_AW'(tab_r))
                                                  : ROM_AW'(tab_r);

    // Burst state advance
    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        busy_next  = busy_reg;
        if (mode)
        begin
            phase_next = '0;
            index_next = '0;
            busy_next  = eff_busy;
        end
        if (eff_busy)
        begin
            phase_next = eff_phase + step_next;
            index_next = eff_i + 1'b1;
            busy_next  = (CMP_W'(eff_i) + 1'b1) < n_w;
        end
    end

    // Configuration and burst state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg        <= AMP_RESET;
            fade_limit_reg <= FADE_RESET;
            phase_reg      <= '0;
            step_reg       <= '0;
            index_reg      <= '0;
            length_reg     <= '0;
            fade_reg       <= '0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_AMPLITUDE:  amp_reg        <= cfg_data[AMP_W-1:0];
                    REG_FADE_LIMIT: fade_limit_reg <= cfg_data[FADE_W-1:0];
                    default:        amp_reg        <= amp_reg;
                endcase
            end
            if (cmd.load)
            begin
                phase_reg  <= phase_next;
                step_reg   <= step_next;
                index_reg  <= index_next;
                length_reg <= length_next;
                fade_reg   <= fade_next;
                busy_reg   <= busy_next;
            end
        end
    end

    // Divider step
    logic [FADE_W:0]   div_t;
    logic              div_ge;
    logic [FADE_W-1:0] rem_step;
    logic [PROD_W+FADE_W-1:0] env_prod;

    assign div_t    = {rem_reg, dvd_reg[SINE_W-1]};
    assign div_ge   = div_t >= {1'b0, den_reg};
    assign rem_step = div_ge ? FADE_W'(div_t - {1'b0, den_reg}) : FADE_W'(div_t);
    assign env_prod = prod_reg * num_reg;

    // Result magnitude and sign
    logic [SINE_W-1:0]   res_mag;
    logic [SAMPLE_W-1:0] mag16;
    logic [SAMPLE_W-1:0] sample_next;

    assign res_mag     = fade_on_reg ? dvd_reg : prod_reg[PROD_W-1 -: SINE_W];
    assign mag16       = {1'b0, res_mag};
    assign sample_next = !act_reg ? '0 : (sign_reg ? (~mag16 + 1'b1) : mag16);

    // Working registers, sine ROM and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg      <= eff_busy;
            last_w_reg   <= eff_busy && ((CMP_W'(eff_i) + 1'b1) == n_w);
            sign_reg     <= tab_addr[TABLE_BITS-1];
            fade_on_reg  <= in_ramp_up || in_ramp_down;
            num_reg      <= num_next;
            den_reg      <= eff_f;
            rom_addr_reg <= rom_addr_next;
        end
        if (cmd.rom_rd)
            rom_data_reg <= QTAB[rom_addr_reg];
        if (cmd.mul)
            prod_reg <= amp_reg * rom_data_reg;
        if (cmd.div_init)
        begin
            rem_reg <= env_prod[PROD_W+FADE_W-1 -: FADE_W];
            dvd_reg <= env_prod[PROD_W-1 -: SINE_W];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[SINE_W-2:0], div_ge};
        end
        if (cmd.out_load)
        begin
            sample_reg <= signed'(sample_next);
            active_reg <= act_reg;
            last_reg   <= last_w_reg;
        end
    end

    assign status.fade_on = fade_on_reg;
    assign sample         = sample_reg;
    assign active         = active_reg;
    assign last           = last_reg;

endmodule
